[src/sfc_pkg.sv]
// Shared types, constants and functions of the sensor frame serializer.
package sfc_pkg;

    localparam int FRAME_LEN   = 26;
    localparam int CRC_SPAN    = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int IDX_W       = $clog2(FRAME_LEN);

    localparam logic [7:0]  HDR_G    = 8'h47;
    localparam logic [7:0]  HDR_Y    = 8'h59;
    localparam logic [7:0]  HDR_R    = 8'h52;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [7:0]       t_byte;

    localparam t_idx LAST_IDX = t_idx'(FRAME_LEN - 1);
    localparam t_idx CRC_LO   = t_idx'(CRC_SPAN);

    typedef struct packed {
        logic [15:0] gyro_x;
        logic [15:0] gyro_y;
        logic [15:0] gyro_z;
        logic [7:0]  gyro_status;
        logic [15:0] accel_x;
        logic [15:0] accel_y;
        logic [15:0] accel_z;
        logic [7:0]  accel_status;
        logic [15:0] mag_pair_a;
        logic [15:0] mag_pair_b;
        logic [15:0] mag_pair_c;
        logic [7:0]  mag_status;
    } t_snapshot;

    // Queue head as seen by the serializer
    typedef struct packed {
        logic      valid;
        t_snapshot data;
    } t_q_head;

    // One byte of CRC-16/Modbus, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input t_byte b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    // Header and payload bytes, positions 0 to CRC_SPAN-1
    function automatic t_byte frame_head(input t_snapshot s, input t_idx idx);
        t_byte fr [CRC_SPAN];
        fr[0]  = HDR_G;
        fr[1]  = HDR_Y;
        fr[2]  = HDR_R;
        fr[3]  = s.gyro_x[7:0];
        fr[4]  = s.gyro_x[15:8];
        fr[5]  = s.gyro_y[7:0];
        fr[6]  = s.gyro_y[15:8];
        fr[7]  = s.gyro_z[7:0];
        fr[8]  = s.gyro_z[15:8];
        fr[9]  = s.gyro_status;
        fr[10] = s.accel_x[7:0];
        fr[11] = s.accel_x[15:8];
        fr[12] = s.accel_y[7:0];
        fr[13] = s.accel_y[15:8];
        fr[14] = s.accel_z[7:0];
        fr[15] = s.accel_z[15:8];
        fr[16] = s.accel_status;
        fr[17] = s.mag_pair_a[7:0];
        fr[18] = s.mag_pair_a[15:8];
        fr[19] = s.mag_pair_b[7:0];
        fr[20] = s.mag_pair_b[15:8];
        fr[21] = s.mag_pair_c[7:0];
        fr[22] = s.mag_pair_c[15:8];
        fr[23] = s.mag_status;
        return (idx < CRC_LO) ? fr[idx] : 8'h00;
    endfunction

endpackage

[src/sfc_if.sv]
// Handshake interfaces: sensor snapshot channel and frame byte channel.
interface sfc_snap_if;
    logic        valid;
    logic        ready;
    logic [15:0] gyro_x;
    logic [15:0] gyro_y;
    logic [15:0] gyro_z;
    logic [7:0]  gyro_status;
    logic [15:0] accel_x;
    logic [15:0] accel_y;
    logic [15:0] accel_z;
    logic [7:0]  accel_status;
    logic [15:0] mag_pair_a;
    logic [15:0] mag_pair_b;
    logic [15:0] mag_pair_c;
    logic [7:0]  mag_status;

    modport source (
        output valid, gyro_x, gyro_y, gyro_z, gyro_status, accel_x, accel_y, accel_z,
               accel_status, mag_pair_a, mag_pair_b, mag_pair_c, mag_status,
        input  ready
    );
    modport sink (
        input  valid, gyro_x, gyro_y, gyro_z, gyro_status, accel_x, accel_y, accel_z,
               accel_status, mag_pair_a, mag_pair_b, mag_pair_c, mag_status,
        output ready
    );
endinterface

interface sfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, frame_byte, frame_last, input ready);
    modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

[src/sensor_frame_crc16_serializer.sv]
// Top level of the sensor frame serializer with CRC-16/Modbus trailer.
//
//   port      dir   kind              payload
//   i_snap    in    valid/ready sink  twelve snapshot fields
//   o_frame   out   valid/ready src   frame_byte, frame_last
//
// Each snapshot produces 26 output bytes, one per cycle while o_frame.ready
// stays high; back-to-back snapshots stream with no gap between frames. The
// CRC advances one byte per emitted header or payload byte.
// Reset (i_rst_n low, synchronous) empties the queue and the output register.
// A stalled output holds its byte; up to QueueDepth snapshots wait meanwhile.
module sensor_frame_crc16_serializer #(
    parameter int QueueDepth = sfc_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfc_snap_if.sink   i_snap,
    sfc_byte_if.source o_frame
);
    import sfc_pkg::*;

    t_q_head w_head;
    logic    w_pop;

    sfc_front #(
        .QueueDepth(QueueDepth)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_snap (i_snap),
        .i_pop  (w_pop),
        .o_head (w_head)
    );

    sfc_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (w_head),
        .o_pop  (w_pop),
        .o_frame(o_frame)
    );

endmodule

[src/sfc_front.sv]
// Front end: accepts snapshots, packs them and holds them in a short queue.
module sfc_front #(
    parameter int QueueDepth = sfc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sfc_snap_if.sink         i_snap,
    input  logic             i_pop,
    output sfc_pkg::t_q_head o_head
);
    import sfc_pkg::*;

    localparam int PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CW = $clog2(QueueDepth + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QueueDepth - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QueueDepth);

    t_snapshot     r_mem [QueueDepth];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    t_snapshot     w_pack;
    logic          w_push;
    logic          w_pop;

    // Pack the incoming fields into one snapshot word
    always_comb begin
        w_pack.gyro_x       = i_snap.gyro_x;
        w_pack.gyro_y       = i_snap.gyro_y;
        w_pack.gyro_z       = i_snap.gyro_z;
        w_pack.gyro_status  = i_snap.gyro_status;
        w_pack.accel_x      = i_snap.accel_x;
        w_pack.accel_y      = i_snap.accel_y;
        w_pack.accel_z      = i_snap.accel_z;
        w_pack.accel_status = i_snap.accel_status;
        w_pack.mag_pair_a   = i_snap.mag_pair_a;
        w_pack.mag_pair_b   = i_snap.mag_pair_b;
        w_pack.mag_pair_c   = i_snap.mag_pair_c;
        w_pack.mag_status   = i_snap.mag_status;
    end

    assign i_snap.ready = (r_count != CNT_FULL);
    assign w_push       = i_snap.valid && i_snap.ready;
    assign w_pop        = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the accepted snapshot
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_pack;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue occupancy above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue occupancy did not grow on push");

endmodule

[src/sfc_back.sv]
// Back end: walks one snapshot through the 26 frame bytes and appends the CRC.
module sfc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfc_pkg::t_q_head i_head,
    output logic             o_pop,
    sfc_byte_if.source       o_frame
);
    import sfc_pkg::*;

    t_snapshot   r_snap;
    logic        r_busy,  n_busy;
    t_idx        r_idx,   n_idx;
    logic [15:0] r_crc,   n_crc;
    logic        r_out_valid, n_out_valid;
    t_byte       r_out_byte;
    logic        r_out_last;
    logic        w_adv;
    t_byte       w_byte;

    // While busy, emit a byte whenever the output register is free or being drained
    assign w_adv = r_busy && (!r_out_valid || o_frame.ready);
    assign o_pop = i_head.valid && (!r_busy || (w_adv && r_idx == LAST_IDX));

    // Select the current frame byte
    always_comb begin
        if (r_idx < CRC_LO) begin
            w_byte = frame_head(r_snap, r_idx);
        end else if (r_idx == CRC_LO) begin
            w_byte = r_crc[7:0];
        end else begin
            w_byte = r_crc[15:8];
        end
    end

    // Next sequencing state
    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        if (o_frame.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_adv) begin
            n_out_valid = 1'b1;
            n_idx       = r_idx + 1'b1;
            if (r_idx < CRC_LO) begin
                n_crc = crc16_byte(r_crc, w_byte);
            end
            if (r_idx == LAST_IDX) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_crc  = CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payload: snapshot, CRC and output byte
    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        if (o_pop) begin
            r_snap <= i_head.data;
        end
        if (w_adv) begin
            r_out_byte <= w_byte;
            r_out_last <= (r_idx == LAST_IDX);
        end
    end

    assign o_frame.valid      = r_out_valid;
    assign o_frame.frame_byte = r_out_byte;
    assign o_frame.frame_last = r_out_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= LAST_IDX))
        else $error("byte index past end of frame");

    a_pop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_busy || r_idx == LAST_IDX))
        else $error("snapshot fetched in mid-frame");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (!r_busy || r_idx == '0))
        else $error("frame still running after last byte");

endmodule

[tb/sensor_frame_crc16_serializer_test.sv]
// Self-checking testbench for the sensor frame serializer with CRC-16/Modbus trailer.
module sensor_frame_crc16_serializer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfc_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int REPORT_LIMIT   = 10;
    localparam int SNAP_ROWS      = 14;

    typedef t_byte t_frame [FRAME_LEN];

    typedef struct {
        t_byte value;
        logic  last;
        int    pos;
    } t_frame_byte_due;

    // Directed snapshots: gx gy gz gs | ax ay az as | ma mb mc ms
    localparam t_snapshot SNAP_TABLE [SNAP_ROWS] = '{
        '{16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00,
          16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF},
        '{16'hAAAA, 16'hAAAA, 16'hAAAA, 8'hAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 8'hAA,
          16'hAAAA, 16'hAAAA, 16'hAAAA, 8'hAA},
        '{16'h5555, 16'h5555, 16'h5555, 8'h55, 16'h5555, 16'h5555, 16'h5555, 8'h55,
          16'h5555, 16'h5555, 16'h5555, 8'h55},
        '{16'h00FF, 16'h00FF, 16'h00FF, 8'h0F, 16'h00FF, 16'h00FF, 16'h00FF, 8'h0F,
          16'h00FF, 16'h00FF, 16'h00FF, 8'h0F},
        '{16'hFF00, 16'hFF00, 16'hFF00, 8'hF0, 16'hFF00, 16'hFF00, 16'hFF00, 8'hF0,
          16'hFF00, 16'hFF00, 16'hFF00, 8'hF0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00,
          16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{16'h0000, 16'h0000, 16'h0000, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 8'h00,
          16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{16'h0000, 16'h0000, 16'h0000, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00,
          16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'hFF,
          16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00},
        '{16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00,
          16'h0000, 16'h0000, 16'h0000, 8'hFF},
        '{16'h8001, 16'h8001, 16'h8001, 8'h81, 16'h8001, 16'h8001, 16'h8001, 8'h81,
          16'h8001, 16'h8001, 16'h8001, 8'h81},
        // Ascending byte values expose any swap in the serial order
        '{16'h0201, 16'h0403, 16'h0605, 8'h07, 16'h0908, 16'h0B0A, 16'h0D0C, 8'h0E,
          16'h100F, 16'h1211, 16'h1413, 8'h15}
    };

    logic i_clk;
    logic i_rst_n;

    sfc_snap_if snap_if ();
    sfc_byte_if frame_if ();

    sensor_frame_crc16_serializer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_snap  (snap_if),
        .o_frame (frame_if)
    );

    t_frame_byte_due frame_bytes_due [$];
    int unsigned     mismatches   = 0;
    int unsigned     quiet_cycles = 0;
    bit              src_idle;
    bit              sink_idle;
    bit              hold_req;

    // Free-running clock, 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Build the full frame of one snapshot, CRC trailer included
    function automatic t_frame frame_for(input t_snapshot s);
        t_frame      f;
        logic [15:0] crc;
        f = '{default: 8'h00};
        f[0]  = HDR_G;
        f[1]  = HDR_Y;
        f[2]  = HDR_R;
        {f[4], f[3]}   = s.gyro_x;
        {f[6], f[5]}   = s.gyro_y;
        {f[8], f[7]}   = s.gyro_z;
        f[9]           = s.gyro_status;
        {f[11], f[10]} = s.accel_x;
        {f[13], f[12]} = s.accel_y;
        {f[15], f[14]} = s.accel_z;
        f[16]          = s.accel_status;
        {f[18], f[17]} = s.mag_pair_a;
        {f[20], f[19]} = s.mag_pair_b;
        {f[22], f[21]} = s.mag_pair_c;
        f[23]          = s.mag_status;
        // Reflected CRC, shift out LSB first
        crc = CRC_INIT;
        for (int k = 0; k < CRC_SPAN; k++) begin
            crc = crc ^ {8'h00, f[k]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        f[CRC_SPAN]     = crc[7:0];
        f[CRC_SPAN + 1] = crc[15:8];
        return f;
    endfunction

    // Favor all-zero and all-one values, otherwise uniform
    function automatic logic [15:0] pick_bits(input int unsigned width);
        logic [15:0] mask;
        mask = 16'((32'd1 << width) - 1);
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return mask;
            default: return 16'($urandom) & mask;
        endcase
    endfunction

    function automatic t_snapshot random_snapshot();
        t_snapshot s;
        s.gyro_x       = pick_bits(16);
        s.gyro_y       = pick_bits(16);
        s.gyro_z       = pick_bits(16);
        s.gyro_status  = 8'(pick_bits(8));
        s.accel_x      = pick_bits(16);
        s.accel_y      = pick_bits(16);
        s.accel_z      = pick_bits(16);
        s.accel_status = 8'(pick_bits(8));
        s.mag_pair_a   = pick_bits(16);
        s.mag_pair_b   = pick_bits(16);
        s.mag_pair_c   = pick_bits(16);
        s.mag_status   = 8'(pick_bits(8));
        return s;
    endfunction

    // Offer one snapshot, wait for the transaction, queue its 26 frame bytes
    task automatic offer_snapshot(input t_snapshot s);
        t_frame f;
        if (src_idle && $urandom_range(0, 3) == 0) begin
            snap_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        snap_if.gyro_x       <= s.gyro_x;
        snap_if.gyro_y       <= s.gyro_y;
        snap_if.gyro_z       <= s.gyro_z;
        snap_if.gyro_status  <= s.gyro_status;
        snap_if.accel_x      <= s.accel_x;
        snap_if.accel_y      <= s.accel_y;
        snap_if.accel_z      <= s.accel_z;
        snap_if.accel_status <= s.accel_status;
        snap_if.mag_pair_a   <= s.mag_pair_a;
        snap_if.mag_pair_b   <= s.mag_pair_b;
        snap_if.mag_pair_c   <= s.mag_pair_c;
        snap_if.mag_status   <= s.mag_status;
        snap_if.valid        <= 1'b1;
        do @(posedge i_clk); while (!snap_if.ready);
        f = frame_for(s);
        for (int k = 0; k < FRAME_LEN; k++) begin
            frame_bytes_due.push_back('{f[k], (k == FRAME_LEN - 1), k});
        end
    endtask

    // Drop valid and hold until every queued frame byte has come out
    task automatic wait_frames_out();
        snap_if.valid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // Drive frame ready: long hold on request, random stall bursts otherwise while sink_idle is set
    initial begin
        frame_if.ready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                frame_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                frame_if.ready <= 1'b1;
            end else if (sink_idle && $urandom_range(0, 4) == 0) begin
                frame_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                frame_if.ready <= 1'b1;
            end
        end
    end

    // Compare each frame byte transaction with the oldest expected byte
    always @(posedge i_clk) begin : check_frame
        t_frame_byte_due due;
        if (i_rst_n && frame_if.valid && frame_if.ready) begin
            if (frame_bytes_due.size() == 0) begin
                note_mismatch($sformatf("unexpected byte %h last %b",
                                        frame_if.frame_byte, frame_if.frame_last));
            end else begin
                due = frame_bytes_due.pop_front();
                if (frame_if.frame_byte !== due.value || frame_if.frame_last !== due.last) begin
                    note_mismatch($sformatf("byte %0d expected %h last %b, got %h last %b",
                                            due.pos, due.value, due.last,
                                            frame_if.frame_byte, frame_if.frame_last));
                end
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((snap_if.valid && snap_if.ready) || (frame_if.valid && frame_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        snap_if.valid        = 1'b0;
        snap_if.gyro_x       = '0;
        snap_if.gyro_y       = '0;
        snap_if.gyro_z       = '0;
        snap_if.gyro_status  = '0;
        snap_if.accel_x      = '0;
        snap_if.accel_y      = '0;
        snap_if.accel_z      = '0;
        snap_if.accel_status = '0;
        snap_if.mag_pair_a   = '0;
        snap_if.mag_pair_b   = '0;
        snap_if.mag_pair_c   = '0;
        snap_if.mag_status   = '0;
        src_idle             = 1'b0;
        sink_idle            = 1'b0;
        hold_req             = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed snapshots back to back, then let the frames drain
        for (int r = 0; r < SNAP_ROWS; r++) begin
            offer_snapshot(SNAP_TABLE[r]);
        end
        wait_frames_out();

        // Random snapshots with stalls on both sides
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        repeat (140) offer_snapshot(random_snapshot());

        // Hold the frame side off while snapshots keep coming
        src_idle = 1'b0;
        hold_req = 1'b1;
        repeat (10) offer_snapshot(random_snapshot());

        src_idle = 1'b1;
        repeat (80) offer_snapshot(random_snapshot());
        wait_frames_out();
        repeat (90) offer_snapshot(random_snapshot());

        // Full rate to the end
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (60) offer_snapshot(random_snapshot());
        wait_frames_out();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && frame_bytes_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
